/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros shared by the envelope rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clock, quiet during reset
`define SPENV_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, quiet during reset
`define SPENV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/spenv_pkg.sv */
// ----------------------------------------------------------------------------
// spenv_pkg
// types and constants of the spline envelope generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spenv_pkg;

   localparam int MAX_POINTS_DEF = 16;

   localparam int TIME_W    = 32;
   localparam int LEVEL_W   = 16;
   localparam int ENTRY_W   = 64;
   localparam int REQ_W     = 104;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_TRIGGER = 2'd1,
      OP_RELEASE = 2'd2,
      OP_TICK    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_ARMED    = 2'd0,
      MODE_HELD     = 2'd1,
      MODE_RELEASED = 2'd2
   } sus_mode_type;

   // register index as decoded from paddr[2]
   localparam logic CSR_ACTIVE_POINTS = 1'b0;
   localparam logic CSR_SUSTAIN_INDEX = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SUS_RD,
      ST_SUS_CHK,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_FETCH_RD,
      ST_FETCH_CAP,
      ST_DECIDE,
      ST_T_WAIT,
      ST_A0,
      ST_A0_WAIT,
      ST_A1,
      ST_A1_WAIT,
      ST_M_T2,
      ST_M_T3,
      ST_M_D0A,
      ST_M_D0B,
      ST_M_D1A,
      ST_M_D1B,
      ST_M_H3,
      ST_M_H4,
      ST_M_H1,
      ST_M_H2,
      ST_FINISH
   } state_type;

endpackage

/* src/spenv_ram.sv */
// ----------------------------------------------------------------------------
// spenv_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spenv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/spenv_div.sv */
// ----------------------------------------------------------------------------
// spenv_div
// serial q16 fraction divider: quot = floor(num * 2^16 / den), num < den
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spenv_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [15:0] quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [15:0] quot_ff, quot_in;
   logic [33:0] shifted;

   // one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      shifted = {rem_ff, 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd16;
         rem_in  = {1'b0, num};
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         if (shifted >= {2'b0, den_ff}) begin
            rem_in  = 33'(shifted - {2'b0, den_ff});
            quot_in = {quot_ff[14:0], 1'b1};
         end else begin
            rem_in  = shifted[32:0];
            quot_in = {quot_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

`include "assert_macros.svh"

   `SPENV_ASSERT_IMPL(a_div_no_restart, start, !busy_ff, "divider restarted while busy")
   `SPENV_ASSERT_IMPL(a_div_done_from_busy, done_ff, $past(busy_ff), "divider done without run")

endmodule

/* src/spline_envelope_generator.sv */
// ----------------------------------------------------------------------------
// spline_envelope_generator
// tension-only kochanek-bartels breakpoint envelope, fixed point
// ----------------------------------------------------------------------------
// requests arrive on req_*: tuser carries the opcode (load, trigger, release,
// tick), tdata the point fields and the tick's phase advance
// only a tick produces a response on rsp_*: the saturated level in tdata
// and the sustain-held flag in tuser
// breakpoints live in one ram of MAX_POINTS entries, one entry per point
// load, trigger and release are carried out in the idle state as they are taken
// a tick reads the sustain point when it is checked, scans the ram over the
// n active points and fetches the span's points; past the last point or on an
// empty span it gives the left level, else it runs the serial divider up to
// three times and evaluates the spline; no request is taken until it is done
// the csr_* apb port holds active_points (0x0) and sustain_index (0x4)
// reset clears phase, sustain state and sustain_index, sets active_points to 1;
// ram contents are undefined until loaded
// a finished response sits in the output register while the next request
// is taken; a tick that finishes while the receiver stalls waits for it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spline_envelope_generator #(
   parameter int MAX_POINTS = spenv_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // point_index, knot_time, point_level, point_tension, delta_time, pad
   input  logic [spenv_pkg::REQ_W-1:0]   req_tdata,
   // opcode
   input  logic [1:0]                    req_tuser,
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // level
   output logic [spenv_pkg::LEVEL_W-1:0] rsp_tdata,
   // held
   output logic                          rsp_tuser,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [spenv_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [spenv_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [spenv_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                          csr_pready
);

   import spenv_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int KW = NW + 1;

   // request fields
   logic [3:0]         f_index;
   logic [31:0]        f_time;
   logic [15:0]        f_level;
   logic [15:0]        f_tension;
   logic [31:0]        f_delta;
   opcode_type         f_op;

   assign f_index   = req_tdata[3:0];
   assign f_time    = req_tdata[35:4];
   assign f_level   = req_tdata[51:36];
   assign f_tension = req_tdata[67:52];
   assign f_delta   = req_tdata[99:68];
   assign f_op      = opcode_type'(req_tuser);

   // configuration registers
   logic [4:0] active_ff;
   logic [3:0] sustain_ff;
   logic       csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 5'd1;
         sustain_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_ACTIVE_POINTS: active_ff  <= csr_pwdata[4:0];
            CSR_SUSTAIN_INDEX: sustain_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_ACTIVE_POINTS: csr_prdata = {27'b0, active_ff};
         CSR_SUSTAIN_INDEX: csr_prdata = {28'b0, sustain_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // control and datapath registers
   state_type          state_ff, state_in;
   sus_mode_type       mode_ff, mode_in;
   logic [31:0]        phase_ff, phase_in;
   logic [31:0]        delta_ff, delta_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      k_ff, k_in;
   logic [1:0]         sel_ff, sel_in;
   logic               direct_ff, direct_in;
   logic [31:0]        tk_ff, tk_in, ti2_ff, ti2_in, ti0_ff, ti0_in, ti3_ff, ti3_in;
   logic signed [15:0] lk_ff, lk_in, l2_ff, l2_in, l0_ff, l0_in, l3_ff, l3_in;
   logic signed [15:0] tek_ff, tek_in, te2_ff, te2_in;
   logic signed [32:0] len_ff, len_in;
   logic [16:0]        t_ff, t_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [16:0]        adj0_ff, adj0_in, adj1_ff, adj1_in;
   logic signed [20:0] h1_ff, h1_in, h2_ff, h2_in, h3_ff, h3_in, h4_ff, h4_in;
   logic signed [34:0] p_ff, p_in, dd0_ff, dd0_in, dd1_ff, dd1_in;
   logic signed [41:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_level_ff, rsp_level_in;
   logic               rsp_held_ff, rsp_held_in;

   // ram, divider and shared multiplier
   logic               ram_wr_en, ram_rd_en;
   logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
   logic               div_start, div_done;
   logic [31:0]        div_num, div_den;
   logic [15:0]        div_quot;
   logic signed [35:0] mul_a;
   logic signed [20:0] mul_b;
   logic signed [56:0] prod;

   spenv_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   spenv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign prod = mul_a * mul_b;

   // ram entry fields
   logic [31:0]        rd_time;
   logic signed [15:0] rd_level, rd_tension;

   assign rd_time    = ram_rd_data[31:0];
   assign rd_level   = ram_rd_data[47:32];
   assign rd_tension = ram_rd_data[63:48];

   // span neighbours
   logic [KW-1:0] k_ext, i0_ext, i2_ext, i3_ext;
   logic          k_is_last;
   logic          sus_check;
   logic          fin_go;

   assign k_ext     = KW'(k_ff);
   assign i0_ext    = (k_ff == '0) ? k_ext : k_ext - KW'(1);
   assign i2_ext    = k_ext + KW'(1);
   assign i3_ext    = ((k_ext + KW'(2)) < KW'(n_ff)) ? k_ext + KW'(2) : k_ext + KW'(1);
   assign k_is_last = (NW'(k_ff) == n_ff - NW'(1));
   assign sus_check = (mode_ff == MODE_ARMED) && (sustain_ff != '0)
                      && (32'(sustain_ff) < MAX_POINTS);
   assign fin_go    = !rsp_valid_ff || rsp_tready;

   // span length and adjust denominators
   logic signed [32:0] len_now, den0, den1;
   logic [31:0]        d_now;

   assign len_now = $signed({1'b0, ti2_ff}) - $signed({1'b0, tk_ff});
   assign den0    = $signed({1'b0, ti2_ff}) - $signed({1'b0, ti0_ff});
   assign den1    = $signed({1'b0, ti3_ff}) - $signed({1'b0, tk_ff});
   assign d_now   = phase_ff - tk_ff;

   // hermite basis from t, t^2, t^3
   logic signed [20:0] ts, t2s, t3s;

   assign ts  = $signed(21'(t_ff));
   assign t2s = $signed(21'(t2_ff));
   assign t3s = $signed(21'(t3_ff));

   // final rounding and saturation
   logic signed [41:0] rounded;

   assign rounded = (acc_ff + 42'sd32768) >>> 16;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && f_op == OP_TICK) begin
               state_in = sus_check ? ST_SUS_RD : ST_SRCH_RD;
            end
         end
         ST_SUS_RD:   state_in = ST_SUS_CHK;
         ST_SUS_CHK:  state_in = ST_SRCH_RD;
         ST_SRCH_RD:  state_in = ST_SRCH_CHK;
         ST_SRCH_CHK: state_in = (cnt_ff == n_ff - NW'(1)) ? ST_FETCH_RD : ST_SRCH_RD;
         ST_FETCH_RD: state_in = ST_FETCH_CAP;
         ST_FETCH_CAP: state_in = (sel_ff == 2'd3) ? ST_DECIDE : ST_FETCH_RD;
         ST_DECIDE: begin
            if (k_is_last || len_now <= 0) begin
               state_in = ST_FINISH;
            end else if (phase_ff > tk_ff && {1'b0, d_now} < len_now[32:0]) begin
               state_in = ST_T_WAIT;
            end else begin
               state_in = ST_A0;
            end
         end
         ST_T_WAIT:  state_in = div_done ? ST_A0 : ST_T_WAIT;
         ST_A0: begin
            if (den0 > 0 && len_ff < den0) begin
               state_in = ST_A0_WAIT;
            end else begin
               state_in = ST_A1;
            end
         end
         ST_A0_WAIT: state_in = div_done ? ST_A1 : ST_A0_WAIT;
         ST_A1: begin
            if (den1 > 0 && len_ff < den1) begin
               state_in = ST_A1_WAIT;
            end else begin
               state_in = ST_M_T2;
            end
         end
         ST_A1_WAIT: state_in = div_done ? ST_M_T2 : ST_A1_WAIT;
         ST_M_T2:    state_in = ST_M_T3;
         ST_M_T3:    state_in = ST_M_D0A;
         ST_M_D0A:   state_in = ST_M_D0B;
         ST_M_D0B:   state_in = ST_M_D1A;
         ST_M_D1A:   state_in = ST_M_D1B;
         ST_M_D1B:   state_in = ST_M_H3;
         ST_M_H3:    state_in = ST_M_H4;
         ST_M_H4:    state_in = ST_M_H1;
         ST_M_H1:    state_in = ST_M_H2;
         ST_M_H2:    state_in = ST_FINISH;
         ST_FINISH:  state_in = fin_go ? ST_IDLE : ST_FINISH;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      int nv;

      nv = int'(active_ff);
      if (nv < 1) nv = 1;
      if (nv > MAX_POINTS) nv = MAX_POINTS;

      req_tready   = (state_ff == ST_IDLE);
      ram_wr_en    = 1'b0;
      ram_wr_addr  = AW'(f_index);
      ram_wr_data  = {f_tension, f_level, f_time};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(cnt_ff);
      div_start    = 1'b0;
      div_num      = d_now;
      div_den      = len_ff[31:0];
      mul_a        = 36'(ts);
      mul_b        = ts;

      mode_in      = mode_ff;
      phase_in     = phase_ff;
      delta_in     = delta_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      direct_in    = direct_ff;
      tk_in        = tk_ff;
      ti2_in       = ti2_ff;
      ti0_in       = ti0_ff;
      ti3_in       = ti3_ff;
      lk_in        = lk_ff;
      l2_in        = l2_ff;
      l0_in        = l0_ff;
      l3_in        = l3_ff;
      tek_in       = tek_ff;
      te2_in       = te2_ff;
      len_in       = len_ff;
      t_in         = t_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      adj0_in      = adj0_ff;
      adj1_in      = adj1_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      h3_in        = h3_ff;
      h4_in        = h4_ff;
      p_in         = p_ff;
      dd0_in       = dd0_ff;
      dd1_in       = dd1_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_level_in = rsp_level_ff;
      rsp_held_in  = rsp_held_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (f_op)
                  OP_LOAD: begin
                     // slots beyond the table are dropped
                     ram_wr_en = (32'(f_index) < MAX_POINTS);
                  end
                  OP_TRIGGER: begin
                     phase_in = '0;
                     mode_in  = MODE_ARMED;
                  end
                  OP_RELEASE: begin
                     mode_in = MODE_RELEASED;
                  end
                  OP_TICK: begin
                     delta_in  = f_delta;
                     n_in      = NW'(nv);
                     cnt_in    = '0;
                     k_in      = '0;
                     sel_in    = '0;
                     direct_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SUS_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(sustain_ff);
         end
         ST_SUS_CHK: begin
            // hold at the sustain point once it is reached
            if (phase_ff >= rd_time) begin
               phase_in = rd_time;
               mode_in  = MODE_HELD;
            end
         end
         ST_SRCH_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(cnt_ff);
         end
         ST_SRCH_CHK: begin
            if (phase_ff > rd_time) begin
               k_in = AW'(cnt_ff);
            end
            cnt_in = cnt_ff + NW'(1);
         end
         ST_FETCH_RD: begin
            ram_rd_en = 1'b1;
            case (sel_ff)
               2'd0:    ram_rd_addr = AW'(k_ext);
               2'd1:    ram_rd_addr = AW'(i2_ext);
               2'd2:    ram_rd_addr = AW'(i0_ext);
               default: ram_rd_addr = AW'(i3_ext);
            endcase
         end
         ST_FETCH_CAP: begin
            case (sel_ff)
               2'd0: begin
                  tk_in  = rd_time;
                  lk_in  = rd_level;
                  tek_in = rd_tension;
               end
               2'd1: begin
                  ti2_in = rd_time;
                  l2_in  = rd_level;
                  te2_in = rd_tension;
               end
               2'd2: begin
                  ti0_in = rd_time;
                  l0_in  = rd_level;
               end
               default: begin
                  ti3_in = rd_time;
                  l3_in  = rd_level;
               end
            endcase
            sel_in = sel_ff + 2'd1;
         end
         ST_DECIDE: begin
            len_in = len_now;
            if (k_is_last || len_now <= 0) begin
               // past the last point or an empty span: left level
               direct_in = 1'b1;
            end else if (phase_ff <= tk_ff) begin
               t_in = '0;
            end else if ({1'b0, d_now} >= len_now[32:0]) begin
               t_in = 17'd65536;
            end else begin
               div_start = 1'b1;
               div_num   = d_now;
               div_den   = len_now[31:0];
            end
         end
         ST_T_WAIT: begin
            if (div_done) t_in = {1'b0, div_quot};
         end
         ST_A0: begin
            div_num = len_ff[31:0];
            div_den = den0[31:0];
            if (den0 <= 0) begin
               adj0_in = '0;
            end else if (len_ff >= den0) begin
               adj0_in = 17'd65536;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_A0_WAIT: begin
            if (div_done) adj0_in = {1'b0, div_quot};
         end
         ST_A1: begin
            div_num = len_ff[31:0];
            div_den = den1[31:0];
            if (den1 <= 0) begin
               adj1_in = '0;
            end else if (len_ff >= den1) begin
               adj1_in = 17'd65536;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_A1_WAIT: begin
            if (div_done) adj1_in = {1'b0, div_quot};
         end
         ST_M_T2: begin
            mul_a = 36'(ts);
            mul_b = ts;
            t2_in = prod[32:16];
         end
         ST_M_T3: begin
            mul_a = 36'(t2s);
            mul_b = ts;
            t3_in = prod[32:16];
         end
         ST_M_D0A: begin
            // (1 - tension) times the key difference across the span
            mul_a = 36'(18'sd32768 - 18'(tek_ff));
            mul_b = 21'(17'(l2_ff) - 17'(l0_ff));
            p_in  = prod[34:0];
            h1_in = 21'(2 * t3s - 3 * t2s + 21'sd65536);
            h2_in = 21'(3 * t2s - 2 * t3s);
            h3_in = 21'(t3s - 2 * t2s + ts);
            h4_in = 21'(t3s - t2s);
         end
         ST_M_D0B: begin
            mul_a  = 36'(p_ff);
            mul_b  = $signed(21'(adj0_ff));
            dd0_in = prod[50:16];
         end
         ST_M_D1A: begin
            mul_a = 36'(18'sd32768 - 18'(te2_ff));
            mul_b = 21'(17'(l3_ff) - 17'(lk_ff));
            p_in  = prod[34:0];
         end
         ST_M_D1B: begin
            mul_a  = 36'(p_ff);
            mul_b  = $signed(21'(adj1_ff));
            dd1_in = prod[50:16];
         end
         ST_M_H3: begin
            mul_a  = 36'(dd0_ff);
            mul_b  = h3_ff;
            acc_in = 42'(prod >>> 15);
         end
         ST_M_H4: begin
            mul_a  = 36'(dd1_ff);
            mul_b  = h4_ff;
            acc_in = acc_ff + 42'(prod >>> 15);
         end
         ST_M_H1: begin
            mul_a  = 36'(lk_ff);
            mul_b  = h1_ff;
            acc_in = acc_ff + 42'(prod);
         end
         ST_M_H2: begin
            mul_a  = 36'(l2_ff);
            mul_b  = h2_ff;
            acc_in = acc_ff + 42'(prod);
         end
         ST_FINISH: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               rsp_held_in  = (mode_ff == MODE_HELD);
               if (direct_ff) begin
                  rsp_level_in = lk_ff;
               end else if (rounded > 42'sd32767) begin
                  rsp_level_in = 16'h7fff;
               end else if (rounded < -42'sd32768) begin
                  rsp_level_in = 16'h8000;
               end else begin
                  rsp_level_in = rounded[15:0];
               end
               // phase runs on unless held, saturating at all ones
               if (mode_ff != MODE_HELD) begin
                  phase_in = ({1'b0, phase_ff} + {1'b0, delta_ff} > 33'hffff_ffff)
                             ? 32'hffff_ffff : phase_ff + delta_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_ARMED;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      delta_ff     <= delta_in;
      n_ff         <= n_in;
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
      sel_ff       <= sel_in;
      direct_ff    <= direct_in;
      tk_ff        <= tk_in;
      ti2_ff       <= ti2_in;
      ti0_ff       <= ti0_in;
      ti3_ff       <= ti3_in;
      lk_ff        <= lk_in;
      l2_ff        <= l2_in;
      l0_ff        <= l0_in;
      l3_ff        <= l3_in;
      tek_ff       <= tek_in;
      te2_ff       <= te2_in;
      len_ff       <= len_in;
      t_ff         <= t_in;
      t2_ff        <= t2_in;
      t3_ff        <= t3_in;
      adj0_ff      <= adj0_in;
      adj1_ff      <= adj1_in;
      h1_ff        <= h1_in;
      h2_ff        <= h2_in;
      h3_ff        <= h3_in;
      h4_ff        <= h4_in;
      p_ff         <= p_in;
      dd0_ff       <= dd0_in;
      dd1_ff       <= dd1_in;
      acc_ff       <= acc_in;
      rsp_level_ff <= rsp_level_in;
      rsp_held_ff  <= rsp_held_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tuser  = rsp_held_ff;

`include "assert_macros.svh"

   // a finishing tick always lands in the output register
   `SPENV_ASSERT_NEXT(a_finish_loads_rsp, (state_ff == ST_FINISH) && fin_go, rsp_valid_ff,
      "finished request did not produce a response")
   // a held envelope does not move its phase
   `SPENV_ASSERT_NEXT(a_held_phase_stable,
      (state_ff == ST_FINISH) && fin_go && (mode_ff == MODE_HELD), $stable(phase_ff),
      "phase moved while held")
   // the divider is only started from the decide and adjust setup states
   `SPENV_ASSERT_IMPL(a_div_start_state, div_start,
      (state_ff == ST_DECIDE) || (state_ff == ST_A0) || (state_ff == ST_A1),
      "divider started outside a setup state")

endmodule

/* dv/tb_spline_envelope_generator.sv */
// ----------------------------------------------------------------------------
// tb_spline_envelope_generator
// self-checking bench: random and directed requests against a built-in
// envelope predictor, responses compared in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spline_envelope_generator;
   import spenv_pkg::*;

   localparam int NPTS      = 16;
   localparam int WDOG_MAX  = 20000;
   localparam int SETTLE    = 200;

   typedef struct packed {
      opcode_type  op;
      logic [3:0]  idx;
      logic [31:0] ptime;
      logic [15:0] plevel;
      logic [15:0] ptension;
      logic [31:0] dt;
   } env_req_type;

   typedef struct packed {
      logic [15:0] level;
      logic        held;
   } env_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic [1:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   spline_envelope_generator uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0]  env_phase;
   sus_mode_type env_mode;
   logic [31:0]  tbl_time [NPTS];
   logic [15:0]  tbl_level [NPTS];
   logic [15:0]  tbl_tension [NPTS];
   logic [4:0]   cfg_points;
   logic [3:0]   cfg_sustain;

   env_req_type pending_reqs [$];
   env_rsp_type expected_levels [$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_send = 1'b0;
   int  failures = 0;
   int  quiet_cycles = 0;

   // floor division by a power of two
   function automatic longint floor_shr(longint x, int s);
      return x >>> s;
   endfunction

   function automatic longint span_ratio(longint num, longint den);
      if (den <= 0 || num <= 0) return 0;
      if (num >= den) return 65536;
      return (num <<< 16) / den;
   endfunction

   function automatic logic [15:0] spline_level(int n);
      int k, i0, i2, i3;
      longint len, t, t2, t3, h1, h2, h3, h4, adj0, adj1;
      longint k0, k1, k2, k3, om1, om2, dd0, ds1, acc, d;
      k = 0;
      for (int i = 0; i < n; i++)
         if (env_phase > tbl_time[i]) k = i;
      if (k == n - 1) return tbl_level[k];
      i0 = (k < 1) ? k : k - 1;
      i2 = k + 1;
      i3 = (k + 2 < n) ? k + 2 : k + 1;
      len = longint'(tbl_time[i2]) - longint'(tbl_time[k]);
      if (len <= 0) return tbl_level[k];
      if (env_phase <= tbl_time[k]) t = 0;
      else begin
         d = longint'(env_phase) - longint'(tbl_time[k]);
         t = (d >= len) ? 65536 : (d <<< 16) / len;
      end
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      h1 = 2 * t3 - 3 * t2 + 65536;
      h2 = 3 * t2 - 2 * t3;
      h3 = t3 - 2 * t2 + t;
      h4 = t3 - t2;
      adj0 = span_ratio(len, longint'(tbl_time[i2]) - longint'(tbl_time[i0]));
      adj1 = span_ratio(len, longint'(tbl_time[i3]) - longint'(tbl_time[k]));
      k0 = longint'($signed(tbl_level[i0]));
      k1 = longint'($signed(tbl_level[k]));
      k2 = longint'($signed(tbl_level[i2]));
      k3 = longint'($signed(tbl_level[i3]));
      om1 = 32768 - longint'($signed(tbl_tension[k]));
      om2 = 32768 - longint'($signed(tbl_tension[i2]));
      dd0 = floor_shr(om1 * (k2 - k0) * adj0, 16);
      ds1 = floor_shr(om2 * (k3 - k1) * adj1, 16);
      acc = k1 * h1 + k2 * h2 + floor_shr(dd0 * h3, 15) + floor_shr(ds1 * h4, 15);
      acc = floor_shr(acc + 32768, 16);
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      return acc[15:0];
   endfunction

   // advance the predictor by one accepted request
   task automatic predict_envelope(input env_req_type r);
      int n;
      longint sum;
      env_rsp_type e;
      case (r.op)
         OP_LOAD: begin
            tbl_time[r.idx] = r.ptime;
            tbl_level[r.idx] = r.plevel;
            tbl_tension[r.idx] = r.ptension;
         end
         OP_TRIGGER: begin
            env_phase = '0;
            env_mode = MODE_ARMED;
         end
         OP_RELEASE: env_mode = MODE_RELEASED;
         default: begin
            n = cfg_points;
            if (n < 1) n = 1;
            if (n > NPTS) n = NPTS;
            if (env_mode == MODE_ARMED && cfg_sustain > 0
                && env_phase >= tbl_time[cfg_sustain]) begin
               env_phase = tbl_time[cfg_sustain];
               env_mode = MODE_HELD;
            end
            e.level = spline_level(n);
            e.held = (env_mode == MODE_HELD);
            expected_levels.push_back(e);
            if (env_mode != MODE_HELD) begin
               sum = longint'(env_phase) + longint'(r.dt);
               env_phase = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
         end
      endcase
   endtask

   // driver: request channel, fed from pending_reqs
   always @(posedge clock) begin
      env_req_type nx;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_envelope(pending_reqs.pop_front());
         if ((!req_tvalid || req_tready)) begin
            if (pending_reqs.size() > 0 && !hold_send
                && ($urandom_range(99) >= send_idle_pct)) begin
               nx = pending_reqs[0];
               req_tvalid <= 1'b1;
               req_tuser <= nx.op;
               req_tdata <= {4'b0, nx.dt, nx.ptension, nx.plevel, nx.ptime, nx.idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: response channel and watchdog
   always @(posedge clock) begin
      env_rsp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_levels.size() == 0) begin
               $error("response with nothing expected: level %h held %b",
                      rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               e = expected_levels.pop_front();
               if (rsp_tdata !== e.level) begin
                  $error("level: expected %h actual %h", e.level, rsp_tdata);
                  failures++;
               end
               if (rsp_tuser !== e.held) begin
                  $error("held: expected %b actual %b", e.held, rsp_tuser);
                  failures++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic push_req(opcode_type op, logic [3:0] idx, logic [31:0] pt,
                           logic [15:0] pl, logic [15:0] pn, logic [31:0] dt);
      env_req_type r;
      r = '{op, idx, pt, pl, pn, dt};
      pending_reqs.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_levels.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // apb write, only while the block is idle
   task automatic csr_write(logic reg_sel, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_sel == CSR_ACTIVE_POINTS) cfg_points = val[4:0];
      else cfg_sustain = val[3:0];
   endtask

   // load a fresh non-decreasing table with random levels
   task automatic load_table(int step_max, bit extreme);
      logic [31:0] t;
      t = extreme ? 32'h0 : $urandom_range(2000);
      for (int i = 0; i < NPTS; i++) begin
         push_req(OP_LOAD, i[3:0], t, 16'($urandom), 16'($urandom), '0);
         if ($urandom_range(7) != 0) t = t + $urandom_range(step_max);
      end
   endtask

   function automatic logic [31:0] rand_dt(int step_max);
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'hFFFF_FFFF;
         2: return 0;
         default: return $urandom_range(step_max / 2);
      endcase
   endfunction

   // a trigger and a run of ticks with an occasional release among them
   task automatic play_note(int step_max, int ticks);
      push_req(OP_TRIGGER, 4'($urandom), $urandom, 16'($urandom), 16'($urandom), $urandom);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(15) == 0)
            push_req(OP_RELEASE, 4'($urandom), $urandom, 16'($urandom),
                     16'($urandom), $urandom);
         else
            push_req(OP_TICK, 4'($urandom), $urandom, 16'($urandom), 16'($urandom),
                     rand_dt(step_max));
      end
   endtask

   initial begin
      int step_max;
      env_phase = '0;
      env_mode = MODE_ARMED;
      cfg_points = 5'd1;
      cfg_sustain = 4'd0;
      for (int i = 0; i < NPTS; i++) begin
         tbl_time[i] = '0;
         tbl_level[i] = '0;
         tbl_tension[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme field values and every opcode
      push_req(OP_LOAD, 4'd0, 32'h0, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
      push_req(OP_LOAD, 4'd1, 32'h0001_0000, 16'h7FFF, 16'h8000, '0);
      push_req(OP_LOAD, 4'd2, 32'h0001_0000, 16'h0000, 16'h0000, '0);
      push_req(OP_LOAD, 4'd3, 32'hFFFF_FFFF, 16'h8000, 16'h8000, '0);
      for (int i = 4; i < NPTS; i++)
         push_req(OP_LOAD, i[3:0], 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, '0);
      push_req(OP_TICK, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h8000);
      push_req(OP_TRIGGER, '0, '0, '0, '0, '0);
      push_req(OP_RELEASE, '0, '0, '0, '0, '0);
      wait_drained();

      csr_write(CSR_ACTIVE_POINTS, 32'd4);
      csr_write(CSR_SUSTAIN_INDEX, 32'd2);
      push_req(OP_TRIGGER, '0, '0, '0, '0, '0);
      push_req(OP_TICK, '0, '0, '0, '0, 32'h4000);
      push_req(OP_TICK, '0, '0, '0, '0, 32'h4000);
      push_req(OP_TICK, '0, '0, '0, '0, 32'h0001_0000);   // advances the phase past sustain
      push_req(OP_TICK, '0, '0, '0, '0, 32'h0001_0000);   // held
      push_req(OP_RELEASE, '0, '0, '0, '0, '0);
      push_req(OP_TICK, '0, '0, '0, '0, 32'hFFFF_FFFF);   // phase saturates
      push_req(OP_TICK, '0, '0, '0, '0, 32'hFFFF_FFFF);   // phase at the last point
      wait_drained();

      // random phases: register settings and idle profiles
      for (int ph = 0; ph < 12; ph++) begin
         case (ph / 4)
            0: begin send_idle_pct = 7;  recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (ph % 4)
            0: csr_write(CSR_ACTIVE_POINTS, 32'd16);
            1: csr_write(CSR_ACTIVE_POINTS, 32'd1);
            2: csr_write(CSR_ACTIVE_POINTS, 32'd2);
            default: csr_write(CSR_ACTIVE_POINTS, $urandom_range(1, 16));
         endcase
         case (ph % 3)
            0: csr_write(CSR_SUSTAIN_INDEX, 32'd0);
            1: csr_write(CSR_SUSTAIN_INDEX, 32'd15);
            default: csr_write(CSR_SUSTAIN_INDEX, $urandom_range(1, 15));
         endcase
         step_max = (ph % 2) ? 32'h0002_0000 : 32'h0000_0800;
         load_table(step_max, ph == 5);
         for (int nt = 0; nt < 3; nt++)
            play_note(step_max * 3, $urandom_range(12, 26));
         // a load into a table in use
         push_req(OP_LOAD, 4'($urandom), 32'h7FFF_FFFF + $urandom_range(1000),
                  16'($urandom), 16'($urandom), $urandom);
         if (ph == 6) begin
            // sender holds off mid-phase until everything expected has arrived
            while (pending_reqs.size() > 30) @(posedge clock);
            hold_send = 1'b1;
            while (req_tvalid || expected_levels.size() != 0) @(posedge clock);
            hold_send = 1'b0;
         end
         wait_drained();
      end

      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
